>>> sv/fst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fst_pkg
// Shared types, codes and helpers for the source tokenizer.
// ----------------------------------------------------------------------------
package fst_pkg;

    // result kind codes
    localparam logic [1:0] KIND_TEXT = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    // token types
    localparam logic [1:0] TOK_WORD   = 2'd0;
    localparam logic [1:0] TOK_NUMBER = 2'd1;
    localparam logic [1:0] TOK_STRING = 2'd2;

    // error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_UNTERM    = 2'd1;
    localparam logic [1:0] ERR_ESC_RANGE = 2'd2;
    localparam logic [1:0] ERR_ESC_EMPTY = 2'd3;

    // characters
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;

    localparam logic [8:0] ESC_LIMIT = 9'd256;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [5:0] {
        MODE_IDLE = 6'b000001,
        MODE_WORD = 6'b000010,
        MODE_STR  = 6'b000100,
        MODE_ESC  = 6'b001000,
        MODE_NUM  = 6'b010000,
        MODE_ERR  = 6'b100000
    } mode_t;

    typedef struct packed {
        mode_t      mode;
        logic [7:0] first_byte;
        logic [1:0] bytes_seen;
        logic       is_number;
        logic [8:0] esc_value;
        logic       esc_digit;
    } tok_state_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] text_byte;
        logic [1:0] token_type;
        logic [1:0] error_code;
        logic       last;
    } result_t;

    localparam tok_state_t STATE_CLEAR = '{
        mode: MODE_IDLE, first_byte: 8'd0, bytes_seen: 2'd0,
        is_number: 1'b0, esc_value: 9'd0, esc_digit: 1'b0
    };

    function automatic result_t mk_text(input logic [7:0] b);
        result_t r;
        r = '0;
        r.kind = KIND_TEXT;
        r.text_byte = b;
        return r;
    endfunction

    function automatic result_t mk_end(input logic [1:0] t);
        result_t r;
        r = '0;
        r.kind = KIND_END;
        r.token_type = t;
        return r;
    endfunction

    function automatic result_t mk_err(input logic [1:0] e);
        result_t r;
        r = '0;
        r.kind = KIND_ERR;
        r.error_code = e;
        return r;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF);
    endfunction

endpackage

>>> sv/fst_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fst_step
// Next-state and result logic for one source byte or end-of-input.
// ----------------------------------------------------------------------------
module fst_step (
    input  fst_pkg::tok_state_t st,
    input  logic [7:0]          in_byte,
    input  logic                end_of_input,
    output fst_pkg::tok_state_t st_next,
    output fst_pkg::result_t    res0,
    output fst_pkg::result_t    res1,
    output logic [1:0]          res_count
);
    import fst_pkg::*;

    logic [11:0] esc_times10;
    logic [8:0]  esc_sat;
    logic [3:0]  digit_val;

    assign digit_val   = in_byte[3:0] - CH_ZERO[3:0];
    // value * 10 + digit, value is at most 256 so 12 bits hold it
    assign esc_times10 = {st.esc_value, 3'b000} + {2'b00, st.esc_value, 1'b0}
                       + {8'd0, digit_val};
    assign esc_sat     = (esc_times10 > {3'd0, ESC_LIMIT}) ? ESC_LIMIT : esc_times10[8:0];

    always_comb begin
        st_next   = st;
        res0      = '0;
        res1      = '0;
        res_count = 2'd0;

        if (end_of_input) begin
            case (st.mode)
                MODE_WORD: begin
                    res0 = mk_end(st.is_number ? TOK_NUMBER : TOK_WORD);
                    res_count = 2'd1;
                end
                MODE_STR, MODE_ESC: begin
                    res0 = mk_err(ERR_UNTERM);
                    res_count = 2'd1;
                end
                MODE_NUM: begin
                    if (!st.esc_digit) begin
                        res0 = mk_err(ERR_ESC_EMPTY);
                    end else if (st.esc_value >= ESC_LIMIT) begin
                        res0 = mk_err(ERR_ESC_RANGE);
                    end else begin
                        res0 = mk_err(ERR_UNTERM);
                    end
                    res_count = 2'd1;
                end
                default: ;
            endcase
            st_next = STATE_CLEAR;
        end else begin
            case (st.mode)
                MODE_IDLE: begin
                    if (is_space(in_byte)) begin
                        st_next = st;
                    end else if (in_byte == CH_QUOTE) begin
                        st_next.mode = MODE_STR;
                    end else begin
                        res0 = mk_text(in_byte);
                        res_count = 2'd1;
                        st_next.mode = MODE_WORD;
                        st_next.first_byte = in_byte;
                        st_next.bytes_seen = 2'd1;
                        st_next.is_number = is_digit(in_byte);
                    end
                end
                MODE_WORD: begin
                    if (is_space(in_byte)) begin
                        res0 = mk_end(st.is_number ? TOK_NUMBER : TOK_WORD);
                        res_count = 2'd1;
                        st_next = STATE_CLEAR;
                    end else begin
                        res0 = mk_text(in_byte);
                        res_count = 2'd1;
                        if (st.bytes_seen == 2'd1) begin
                            // signed number: sign then digit
                            if ((st.first_byte == CH_PLUS || st.first_byte == CH_MINUS)
                                && is_digit(in_byte)) begin
                                st_next.is_number = 1'b1;
                            end
                            st_next.bytes_seen = 2'd2;
                        end
                    end
                end
                MODE_STR: begin
                    if (in_byte == CH_QUOTE) begin
                        res0 = mk_end(TOK_STRING);
                        res_count = 2'd1;
                        st_next = STATE_CLEAR;
                    end else if (in_byte == CH_BSLASH) begin
                        st_next.mode = MODE_ESC;
                    end else begin
                        res0 = mk_text(in_byte);
                        res_count = 2'd1;
                    end
                end
                MODE_ESC: begin
                    st_next.mode = MODE_STR;
                    res_count = 2'd1;
                    if (in_byte == CH_N) begin
                        res0 = mk_text(CH_LF);
                    end else if (in_byte == CH_R) begin
                        res0 = mk_text(CH_CR);
                    end else if (in_byte == CH_T) begin
                        res0 = mk_text(CH_TAB);
                    end else if (in_byte == CH_ZERO) begin
                        st_next.mode = MODE_NUM;
                        st_next.esc_value = 9'd0;
                        st_next.esc_digit = 1'b0;
                        res_count = 2'd0;
                    end else begin
                        res0 = mk_text(in_byte);
                    end
                end
                MODE_NUM: begin
                    if (is_digit(in_byte)) begin
                        st_next.esc_value = esc_sat;
                        st_next.esc_digit = 1'b1;
                    end else if (!st.esc_digit) begin
                        res0 = mk_err(ERR_ESC_EMPTY);
                        res_count = 2'd1;
                        st_next.mode = MODE_ERR;
                    end else if (st.esc_value >= ESC_LIMIT) begin
                        res0 = mk_err(ERR_ESC_RANGE);
                        res_count = 2'd1;
                        st_next.mode = MODE_ERR;
                    end else begin
                        // emit escaped byte, then handle the ending byte as in string mode
                        res0 = mk_text(st.esc_value[7:0]);
                        st_next.mode = MODE_STR;
                        st_next.esc_value = 9'd0;
                        st_next.esc_digit = 1'b0;
                        if (in_byte == CH_QUOTE) begin
                            res1 = mk_end(TOK_STRING);
                            res_count = 2'd2;
                            st_next = STATE_CLEAR;
                        end else if (in_byte == CH_BSLASH) begin
                            res_count = 2'd1;
                            st_next.mode = MODE_ESC;
                        end else begin
                            res1 = mk_text(in_byte);
                            res_count = 2'd2;
                        end
                    end
                end
                default: begin
                    st_next.mode = MODE_ERR;
                end
            endcase
        end

        if (res_count == 2'd1) begin
            res0.last = 1'b1;
        end else if (res_count == 2'd2) begin
            res1.last = 1'b1;
        end
    end

endmodule

>>> sv/fst_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fst_queue
// Small result queue: takes up to two results a cycle, delivers one while out_ready is high.
// ----------------------------------------------------------------------------
module fst_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [1:0]       push_count,
    input  fst_pkg::result_t push0,
    input  fst_pkg::result_t push1,
    output logic             has_room,
    output logic             out_valid,
    input  logic             out_ready,
    output fst_pkg::result_t out_data
);
    import fst_pkg::*;

    result_t             entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg,  count_next;
    logic                pop;
    logic [QUEUE_AW-1:0] wr_ptr_plus1;

    assign pop          = out_valid && out_ready;
    assign out_valid    = (count_reg != '0);
    assign out_data     = entry_reg[rd_ptr_reg];
    // room for the worst case of two results
    assign has_room     = (count_reg <= (QUEUE_AW+1)'(QUEUE_DEPTH - 2));
    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + push_count[QUEUE_AW-1:0];
        rd_ptr_next = rd_ptr_reg + {{(QUEUE_AW-1){1'b0}}, pop};
        count_next  = count_reg + {{(QUEUE_AW-1){1'b0}}, push_count}
                    - {{QUEUE_AW{1'b0}}, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_count != 2'd0) begin
            entry_reg[wr_ptr_reg] <= push0;
        end
        if (push_count == 2'd2) begin
            entry_reg[wr_ptr_plus1] <= push1;
        end
    end

endmodule

>>> sv/forth_source_tokenizer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// forth_source_tokenizer_core
// Whitespace-delimited tokenizer with quoted strings and escape decoding.
// ----------------------------------------------------------------------------
// Channel   Dir  tdata                                  tuser         tlast
// s_        in   [7:0] in_byte                          -             end_of_input
// m_        out  [7:0] text_byte, [9:8] token_type,     [1:0] kind    last result of item
//                [11:10] error_code
//
// One input transfer per cycle while s_tready is high: the tokenizer state updates
// in the accept cycle and the results are written into a four-entry result queue.
// s_tready is high while the queue has room for two results. A two-result item
// (numeric escape closed by another byte) always follows three items with no
// result, so with m_tready held high the input never stalls.
// Synchronous active-low reset returns to idle and empties the queue.
// ----------------------------------------------------------------------------
module forth_source_tokenizer_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // end_of_input
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] text_byte, [9:8] token_type,
                                   // [11:10] error_code, [15:12] pad
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast
);
    import fst_pkg::*;

    tok_state_t state_reg, state_next;
    result_t    res0, res1, q_out;
    logic [1:0] res_count;
    logic [1:0] push_count;
    logic       accept;

    assign accept     = s_tvalid && s_tready;
    assign push_count = accept ? res_count : 2'd0;

    fst_step u_step (
        .st           (state_reg),
        .in_byte      (s_tdata),
        .end_of_input (s_tlast),
        .st_next      (state_next),
        .res0         (res0),
        .res1         (res1),
        .res_count    (res_count)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_CLEAR;
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    fst_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_count (push_count),
        .push0      (res0),
        .push1      (res1),
        .has_room   (s_tready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (q_out)
    );

    assign m_tdata = {4'b0000, q_out.error_code, q_out.token_type, q_out.text_byte};
    assign m_tuser = q_out.kind;
    assign m_tlast = q_out.last;

endmodule
